/* hw/rtl/aigs_pkg.sv */
// ----------------------------------------------------------------------------
// aigs_pkg
// shared types and constants of the alpha invert gradient shader
// ----------------------------------------------------------------------------
package aigs_pkg;

  localparam int PIX_W   = 32;
  localparam int OFF_W   = 26;
  localparam int REG_W   = 27;
  localparam int FMT_W   = 2;
  localparam int IDX_W   = 2;
  localparam int CHAN_W  = 5;
  localparam int DVS_W   = REG_W + 2;
  localparam int QUOT_W  = CHAN_W + 1;

  localparam logic [FMT_W-1:0] FMT_ARGB8888 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_ARGB1555 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_ARGB4444 = 2'd2;

  localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [IDX_W-1:0] REG_REGION_BYTES = 2'd1;
  localparam logic [IDX_W-1:0] REG_SOFT_SHADE   = 2'd2;

  localparam logic [PIX_W-1:0] ALPHA8_MASK = 32'hFF00_0000;
  localparam logic [15:0]      ALPHA4_MASK = 16'hF000;
  localparam logic [15:0]      ALPHA1_MASK = 16'h8000;

  typedef struct packed {
    logic s2;
    logic s3;
  } div_en_t;

endpackage

/* hw/rtl/alpha_invert_gradient_shader_core.sv */
// ----------------------------------------------------------------------------
// alpha_invert_gradient_shader_core
// alpha inversion and region gradient shading of one pixel per request
// ----------------------------------------------------------------------------
// Takes one pixel request per clock and passes it through four register
// stages: product and divisor forming, two stages of the quotient unit that
// resolves three bits each per channel, and the final subtract and pack into
// the output register. Throughput is one pixel per cycle whenever the output
// side accepts. Configuration is written through cfg_we, cfg_index and
// cfg_wdata and must not change while requests are in flight.
module alpha_invert_gradient_shader_core import aigs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   in_pixel_in,
  input  logic [OFF_W-1:0]   in_byte_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_pixel_out,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]   cfg_wdata
);

  logic [FMT_W-1:0] fmt_r;
  logic [REG_W-1:0] region_r;
  logic             soft_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [PIX_W-1:0] res1_r, res2_r, res3_r;
  logic             shade1_r, shade2_r, shade3_r;
  logic             rw1_r, rw2_r, rw3_r;
  logic [PIX_W-1:0] xa1_r, xg1_r;
  logic [DVS_W-1:0] dvs1_r;
  logic [PIX_W-1:0] out_r;

  logic [PIX_W-1:0]  res1_nxt;
  logic              shade1_nxt;
  logic              rw1_nxt;
  logic [PIX_W-1:0]  xa1_nxt, xg1_nxt;
  logic [DVS_W-1:0]  dvs1_nxt;
  logic [15:0]       p1555;
  logic [CHAN_W-1:0] r_in, g_in, b_in, na_in;
  logic [REG_W-1:0]  area;
  logic              dbl;
  logic [PIX_W-2:0]  prod_a, prod_g;

  logic [QUOT_W-1:0] qa, qg;
  logic [CHAN_W-1:0] na3, ng3, sa3, sg3;
  logic [PIX_W-1:0]  out_nxt;
  div_en_t           div_en;

  function automatic logic [CHAN_W-1:0] shade_sub(input logic [CHAN_W-1:0] n,
                                                  input logic [QUOT_W-1:0] q);
    logic [CHAN_W-1:0] v;
    if (q > {1'b0, n}) begin
      v = '0;
    end else begin
      v = n - q[CHAN_W-1:0];
    end
    return v;
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_ARGB1555;
      region_r <= REG_W'(1);
      soft_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: fmt_r    <= cfg_wdata[FMT_W-1:0];
        REG_REGION_BYTES: region_r <= cfg_wdata;
        REG_SOFT_SHADE:   soft_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign div_en   = '{s2: rdy2, s3: rdy3};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: format decode, products and divisor
  always_comb begin
    p1555      = in_pixel_in[15:0] ^ ALPHA1_MASK;
    r_in       = p1555[14:10];
    g_in       = p1555[9:5];
    b_in       = p1555[4:0];
    rw1_nxt    = r_in >= b_in;
    na_in      = rw1_nxt ? r_in : b_in;
    shade1_nxt = 1'b0;
    unique case (fmt_r)
      FMT_ARGB8888: res1_nxt = in_pixel_in ^ ALPHA8_MASK;
      FMT_ARGB4444: res1_nxt = {16'h0000, in_pixel_in[15:0] ^ ALPHA4_MASK};
      FMT_ARGB1555: begin
        res1_nxt   = p1555[15] ? {16'h0000, p1555} : '0;
        shade1_nxt = p1555[15];
      end
      default: res1_nxt = in_pixel_in;
    endcase
    area = (region_r == '0) ? REG_W'(1) : region_r;
    dbl  = !soft_r && rw1_nxt;
    if (soft_r) begin
      dvs1_nxt = {area, 2'b00};
    end else if (rw1_nxt) begin
      dvs1_nxt = {1'b0, area, 1'b0} + {2'b00, area};
    end else begin
      dvs1_nxt = {1'b0, area, 1'b0};
    end
    prod_a  = (PIX_W-1)'(na_in * in_byte_offset);
    prod_g  = (PIX_W-1)'(g_in * in_byte_offset);
    xa1_nxt = dbl ? {prod_a, 1'b0} : {1'b0, prod_a};
    xg1_nxt = dbl ? {prod_g, 1'b0} : {1'b0, prod_g};
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      res1_r   <= res1_nxt;
      shade1_r <= shade1_nxt;
      rw1_r    <= rw1_nxt;
      xa1_r    <= xa1_nxt;
      xg1_r    <= xg1_nxt;
      dvs1_r   <= dvs1_nxt;
    end
    if (rdy2) begin
      res2_r   <= res1_r;
      shade2_r <= shade1_r;
      rw2_r    <= rw1_r;
    end
    if (rdy3) begin
      res3_r   <= res2_r;
      shade3_r <= shade2_r;
      rw3_r    <= rw2_r;
    end
    if (rdy4) begin
      out_r <= out_nxt;
    end
  end

  // stages 2 and 3: quotients for the dominant channel and green
  aigs_div u_div_a (
    .clk      (clk),
    .en       (div_en),
    .dividend (xa1_r),
    .divisor  (dvs1_r),
    .quot     (qa)
  );

  aigs_div u_div_g (
    .clk      (clk),
    .en       (div_en),
    .dividend (xg1_r),
    .divisor  (dvs1_r),
    .quot     (qg)
  );

  // stage 4: subtract and pack
  always_comb begin
    na3 = rw3_r ? res3_r[14:10] : res3_r[4:0];
    ng3 = res3_r[9:5];
    sa3 = shade_sub(na3, qa);
    sg3 = shade_sub(ng3, qg);
    if (!shade3_r) begin
      out_nxt = res3_r;
    end else if (rw3_r) begin
      out_nxt = {16'h0000, 1'b1, sa3, sg3, res3_r[4:0]};
    end else begin
      out_nxt = {16'h0000, 1'b1, res3_r[14:10], sg3, sa3};
    end
  end

  assign out_valid     = v4_r;
  assign out_pixel_out = out_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && rdy4 |=> out_valid)
    else $error("request lost between last stages");

  a_shade_form: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && rdy4 && shade3_r |=> out_pixel_out[31:15] == 17'h00001)
    else $error("shaded pixel lost its alpha bit or upper half");

  a_shade_darkens: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && rdy4 && shade3_r |=>
      out_pixel_out[9:5] <= $past(res3_r[9:5]))
    else $error("green channel got brighter");

endmodule

/* hw/rtl/aigs_div.sv */
// ----------------------------------------------------------------------------
// aigs_div
// two-stage quotient unit, bit 5 set for any quotient of 32 or more
// ----------------------------------------------------------------------------
module aigs_div import aigs_pkg::*; (
  input  logic               clk,
  input  div_en_t            en,
  input  logic [PIX_W-1:0]   dividend,
  input  logic [DVS_W-1:0]   divisor,
  output logic [QUOT_W-1:0]  quot
);

  localparam int CMP_W = DVS_W + QUOT_W;

  logic [PIX_W-1:0]  rem2_r;
  logic [QUOT_W-1:0] q2_r;
  logic [DVS_W-1:0]  dvs2_r;
  logic [QUOT_W-1:0] q3_r;

  logic [CMP_W-1:0]  rem2_nxt;
  logic [QUOT_W-1:0] q2_nxt;
  logic [CMP_W-1:0]  cand2;
  logic [CMP_W-1:0]  rem3;
  logic [QUOT_W-1:0] q3_nxt;
  logic [CMP_W-1:0]  cand3;

  // overflow check, then quotient bits 4 and 3
  always_comb begin
    rem2_nxt = CMP_W'(dividend);
    q2_nxt   = '0;
    cand2    = CMP_W'({divisor, {CHAN_W{1'b0}}});
    if (rem2_nxt >= cand2) begin
      q2_nxt[CHAN_W] = 1'b1;
    end
    for (int k = CHAN_W - 1; k >= CHAN_W - 2; k--) begin
      cand2 = CMP_W'(divisor) << k;
      if (rem2_nxt >= cand2) begin
        rem2_nxt  = rem2_nxt - cand2;
        q2_nxt[k] = 1'b1;
      end
    end
  end

  // quotient bits 2 to 0
  always_comb begin
    rem3   = CMP_W'(rem2_r);
    q3_nxt = q2_r;
    cand3  = '0;
    for (int k = CHAN_W - 3; k >= 0; k--) begin
      cand3 = CMP_W'(dvs2_r) << k;
      if (rem3 >= cand3) begin
        rem3      = rem3 - cand3;
        q3_nxt[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      rem2_r <= rem2_nxt[PIX_W-1:0];
      q2_r   <= q2_nxt;
      dvs2_r <= divisor;
    end
    if (en.s3) begin
      q3_r <= q3_nxt;
    end
  end

  assign quot = q3_r;

endmodule
